// File: rtl/rpi_pkg.sv
// Shared register codes and queue status type for the ray/plane intersect block.
package rpi_pkg;

    // Register word indexes on the configuration port
    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_DIST     = 3'd3;
    localparam logic [2:0] REG_EPS      = 3'd4;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: rtl/rpi_fifo.sv
// Two-entry item queue between the classify front and the divide back.
module rpi_fifo #(
    parameter int W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_pop,
    output logic [W-1:0]         o_rdata,
    output rpi_pkg::t_fifo_stat  o_stat
);
    import rpi_pkg::*;

    logic [W-1:0] r_mem [0:1];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_wdata;
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

// File: rtl/rpi_front.sv
// Front: dot products, plane test and item classification, pushed into the queue.
module rpi_front #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int QW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic                  i_two_sided,
    input  logic signed [CW-1:0]  i_origin_x,
    input  logic signed [CW-1:0]  i_origin_y,
    input  logic signed [CW-1:0]  i_origin_z,
    input  logic signed [CW-1:0]  i_dir_x,
    input  logic signed [CW-1:0]  i_dir_y,
    input  logic signed [CW-1:0]  i_dir_z,
    input  logic signed [CW-1:0]  i_normal_x,
    input  logic signed [CW-1:0]  i_normal_y,
    input  logic signed [CW-1:0]  i_normal_z,
    input  logic signed [CW-1:0]  i_plane_dist,
    input  logic [CW-2:0]         i_eps,
    input  rpi_pkg::t_fifo_stat   i_fifo_stat,
    output logic                  o_push,
    output logic [QW-1:0]         o_push_data
);
    import rpi_pkg::*;

    localparam int PW   = 2 * CW;
    localparam int DENW = 2 * CW + 2;
    localparam int NUMW = 2 * CW + 3;

    logic                 en;
    logic                 r_s1_valid, r_s2_valid;
    logic                 r_s1_mode, r_s1_two, r_s2_mode, r_s2_two;
    logic [6*CW-1:0]      r_s1_od, r_s2_od;
    logic signed [PW-1:0] r_pdx, r_pdy, r_pdz, r_pox, r_poy, r_poz;
    logic signed [DENW-1:0] r_den;
    logic signed [NUMW-1:0] r_num;
    logic signed [DENW-1:0] eps_w;
    logic                 hit, ray_miss, qneg;

    // Hold while stage 2 has an item and the queue is full
    assign en      = !r_s2_valid || !i_fifo_stat.full;
    assign o_ready = en;
    assign o_push  = r_s2_valid && !i_fifo_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 1: form the six products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pdx     <= i_normal_x * i_dir_x;
            r_pdy     <= i_normal_y * i_dir_y;
            r_pdz     <= i_normal_z * i_dir_z;
            r_pox     <= i_origin_x * i_normal_x;
            r_poy     <= i_origin_y * i_normal_y;
            r_poz     <= i_origin_z * i_normal_z;
            r_s1_mode <= i_mode;
            r_s1_two  <= i_two_sided;
            r_s1_od   <= {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z};
        end
    end

    // Stage 2: sum into denominator and numerator
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= DENW'(r_pdx) + DENW'(r_pdy) + DENW'(r_pdz);
            r_num <= (NUMW'(i_plane_dist) <<< FB)
                     - (NUMW'(r_pox) + NUMW'(r_poy) + NUMW'(r_poz));
            r_s2_mode <= r_s1_mode;
            r_s2_two  <= r_s1_two;
            r_s2_od   <= r_s1_od;
        end
    end

    // Classify: facing test, parallel test, ray sign test
    always_comb begin
        eps_w    = DENW'($signed({1'b0, i_eps})) <<< FB;
        hit      = ((r_den <= -eps_w) || (r_s2_two && (r_den >= eps_w)))
                   && (r_den != '0);
        ray_miss = r_s2_mode && (r_num != '0) && (r_num[NUMW-1] != r_den[DENW-1]);
        qneg     = r_num[NUMW-1] ^ r_den[DENW-1];
    end

    assign o_push_data = {hit && !ray_miss, qneg, r_num, r_den, r_s2_od};

endmodule

// File: rtl/rpi_back.sv
// Back: pipelined restoring divide for t, then point evaluation and output register.
module rpi_back #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int QW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rpi_pkg::t_fifo_stat   i_fifo_stat,
    input  logic [QW-1:0]         i_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output logic signed [CW-1:0]  o_hit_param,
    output logic signed [CW-1:0]  o_point_x,
    output logic signed [CW-1:0]  o_point_y,
    output logic signed [CW-1:0]  o_point_z
);
    import rpi_pkg::*;

    localparam int PW   = 2 * CW;
    localparam int DENW = 2 * CW + 2;
    localparam int NUMW = 2 * CW + 3;
    localparam int NW   = NUMW + FB;
    localparam int WW   = (NW > DENW + CW) ? NW : DENW + CW;
    localparam int SUMW = 2 * CW + 1;
    localparam int SW   = SUMW - FB;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic            hit;
        logic            qneg;
        logic            ovf;
        logic [WW-1:0]   rem;
        logic [DENW-1:0] dv;
        logic [CW-1:0]   q;
        logic [6*CW-1:0] od;
    } t_div;

    logic                   en;
    logic                   q_hit, q_qneg;
    logic signed [NUMW-1:0] q_num;
    logic signed [DENW-1:0] q_den;
    logic [6*CW-1:0]        q_od;

    logic                   r_a_valid, r_a_hit, r_a_qneg;
    logic [NUMW-1:0]        r_a_magn;
    logic [DENW-1:0]        r_a_magd;
    logic [6*CW-1:0]        r_a_od;

    t_div                   r_div [0:CW];
    logic                   r_div_vld [0:CW];

    logic                   r_t_valid, r_t_hit;
    logic signed [CW-1:0]   r_t;
    logic [6*CW-1:0]        r_t_od;

    logic                   r_m_valid, r_m_hit;
    logic signed [CW-1:0]   r_m_t, r_m_ox, r_m_oy, r_m_oz;
    logic signed [PW-1:0]   r_m_px, r_m_py, r_m_pz;

    logic                   r_out_valid, r_out_hit;
    logic signed [CW-1:0]   r_out_t, r_out_x, r_out_y, r_out_z;

    logic signed [CW-1:0]   n_t;
    logic [CW-1:0]          last_q;

    // Round toward minus infinity and saturate one point coordinate
    function automatic logic signed [CW-1:0] point_sat(input logic signed [CW-1:0] o,
                                                       input logic signed [PW-1:0] p);
        logic signed [SUMW-1:0] sum;
        logic signed [SW-1:0]   sh;
        sum = (SUMW'(o) <<< FB) + SUMW'(p);
        sh  = SW'(sum >>> FB);
        if (sh > SW'(CMAX))      point_sat = CMAX;
        else if (sh < SW'(CMIN)) point_sat = CMIN;
        else                     point_sat = CW'(sh);
    endfunction

    // Stall the whole back when the output item is not taken
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_fifo_stat.empty;

    assign {q_hit, q_qneg, q_num, q_den, q_od} = i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_div_vld[0] <= 1'b0;
            r_t_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid    <= !i_fifo_stat.empty;
            r_div_vld[0] <= r_a_valid;
            r_t_valid    <= r_div_vld[CW];
            r_m_valid    <= r_t_valid;
            r_out_valid  <= r_m_valid;
        end
    end

    // Stage A: take magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_hit  <= q_hit;
            r_a_qneg <= q_qneg;
            r_a_magn <= q_num[NUMW-1] ? NUMW'(-q_num) : NUMW'(q_num);
            r_a_magd <= q_den[DENW-1] ? DENW'(-q_den) : DENW'(q_den);
            r_a_od   <= q_od;
        end
    end

    // Divide stage 0: scale numerator and flag a quotient beyond range
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0].hit  <= r_a_hit;
            r_div[0].qneg <= r_a_qneg;
            r_div[0].rem  <= WW'({r_a_magn, {FB{1'b0}}});
            r_div[0].ovf  <= WW'({r_a_magn, {FB{1'b0}}}) >= (WW'(r_a_magd) << CW);
            r_div[0].dv   <= r_a_magd;
            r_div[0].q    <= '0;
            r_div[0].od   <= r_a_od;
        end
    end

    // Divide stages: one quotient bit each, most significant first
    for (genvar j = 1; j <= CW; j++) begin : g_div
        localparam int B = CW - j;
        logic [WW-1:0] trial;
        t_div          n_div;
        assign trial = WW'(r_div[j-1].dv) << B;

        // Subtract the shifted divisor where it fits
        always_comb begin
            n_div = r_div[j-1];
            if (r_div[j-1].rem >= trial) begin
                n_div.rem  = r_div[j-1].rem - trial;
                n_div.q[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[j] <= 1'b0;
            end else if (en) begin
                r_div_vld[j] <= r_div_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[j] <= n_div;
            end
        end
    end

    // Saturate and sign the quotient
    always_comb begin
        last_q = r_div[CW].q;
        if (!r_div[CW].qneg) begin
            if (r_div[CW].ovf || last_q[CW-1]) n_t = CMAX;
            else                               n_t = $signed(last_q);
        end else begin
            if (r_div[CW].ovf || (last_q[CW-1] && (last_q[CW-2:0] != '0))) n_t = CMIN;
            else                                                          n_t = -$signed(last_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t     <= n_t;
            r_t_hit <= r_div[CW].hit;
            r_t_od  <= r_div[CW].od;
        end
    end

    // Multiply t by the direction
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_hit <= r_t_hit;
            r_m_t   <= r_t;
            r_m_ox  <= $signed(r_t_od[6*CW-1:5*CW]);
            r_m_oy  <= $signed(r_t_od[5*CW-1:4*CW]);
            r_m_oz  <= $signed(r_t_od[4*CW-1:3*CW]);
            r_m_px  <= r_t * $signed(r_t_od[3*CW-1:2*CW]);
            r_m_py  <= r_t * $signed(r_t_od[2*CW-1:CW]);
            r_m_pz  <= r_t * $signed(r_t_od[CW-1:0]);
        end
    end

    // Output register: point sums, zero on miss
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= r_m_hit;
            r_out_t   <= r_m_hit ? r_m_t : '0;
            r_out_x   <= r_m_hit ? point_sat(r_m_ox, r_m_px) : '0;
            r_out_y   <= r_m_hit ? point_sat(r_m_oy, r_m_py) : '0;
            r_out_z   <= r_m_hit ? point_sat(r_m_oz, r_m_pz) : '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_hit_param = r_out_t;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r_out_z;

endmodule

// File: rtl/ray_plane_intersect.sv
// Top level: plane registers, classify front, item queue and divide back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready   | mode, two_sided, origin_xyz, dir_xyz
//  output   | o_out_valid / i_out_ready | hit, hit_param, point_xyz
//  config   | psel penable pwrite pready| paddr, pwdata, prdata
//
// One item per cycle sustained while the output is taken; an accepted item passes
// through two front stages, one queue entry, magnitude and divider setup stages,
// one quotient bit per stage, then quotient, product and output registers.
// Reset is synchronous; it clears valid state and the plane registers, but sets normal z to 1.0 and eps to one LSB.
// A stalled output holds the whole back; the two-entry queue then fills and
// the front drops o_in_ready.
module ray_plane_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [((COORD_WIDTH > 32) ? 3 : 2) + 2:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                      pready,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic                                      i_mode,
    input  logic                                      i_two_sided,
    input  logic signed [COORD_WIDTH-1:0]             i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]             i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]             i_origin_z,
    input  logic signed [COORD_WIDTH-1:0]             i_dir_x,
    input  logic signed [COORD_WIDTH-1:0]             i_dir_y,
    input  logic signed [COORD_WIDTH-1:0]             i_dir_z,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic                                      o_hit,
    output logic signed [COORD_WIDTH-1:0]             o_hit_param,
    output logic signed [COORD_WIDTH-1:0]             o_point_x,
    output logic signed [COORD_WIDTH-1:0]             o_point_y,
    output logic signed [COORD_WIDTH-1:0]             o_point_z
);
    import rpi_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int DATA_W = (CW > 32) ? 64 : 32;
    localparam int ALO    = (CW > 32) ? 3 : 2;
    localparam int ADDR_W = ALO + 3;
    localparam int QW     = 2 + (2 * CW + 3) + (2 * CW + 2) + 6 * CW;

    logic signed [CW-1:0] r_normal_x, r_normal_y, r_normal_z, r_plane_dist;
    logic [CW-2:0]        r_eps;
    logic [2:0]           widx;
    logic                 wr_en;
    logic                 push, pop;
    logic [QW-1:0]        push_data, pop_data;
    t_fifo_stat           fifo_stat;

    assign pready = 1'b1;
    assign widx   = paddr[ADDR_W-1:ALO];
    assign wr_en  = psel && penable && pwrite && pready;

    // Write plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_x   <= '0;
            r_normal_y   <= '0;
            r_normal_z   <= CW'(1) << FRAC_BITS;
            r_plane_dist <= '0;
            r_eps        <= (CW-1)'(1);
        end else if (wr_en) begin
            unique case (widx)
                REG_NORMAL_X: r_normal_x   <= pwdata[CW-1:0];
                REG_NORMAL_Y: r_normal_y   <= pwdata[CW-1:0];
                REG_NORMAL_Z: r_normal_z   <= pwdata[CW-1:0];
                REG_DIST:     r_plane_dist <= pwdata[CW-1:0];
                REG_EPS:      r_eps        <= pwdata[CW-2:0];
                default: ;
            endcase
        end
    end

    // Read back plane registers
    always_comb begin
        unique case (widx)
            REG_NORMAL_X: prdata = DATA_W'(r_normal_x);
            REG_NORMAL_Y: prdata = DATA_W'(r_normal_y);
            REG_NORMAL_Z: prdata = DATA_W'(r_normal_z);
            REG_DIST:     prdata = DATA_W'(r_plane_dist);
            REG_EPS:      prdata = DATA_W'(r_eps);
            default:      prdata = '0;
        endcase
    end

    rpi_front #(.CW(CW), .FB(FRAC_BITS), .QW(QW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_mode       (i_mode),
        .i_two_sided  (i_two_sided),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_origin_z   (i_origin_z),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_dir_z      (i_dir_z),
        .i_normal_x   (r_normal_x),
        .i_normal_y   (r_normal_y),
        .i_normal_z   (r_normal_z),
        .i_plane_dist (r_plane_dist),
        .i_eps        (r_eps),
        .i_fifo_stat  (fifo_stat),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    rpi_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_data),
        .i_pop   (pop),
        .o_rdata (pop_data),
        .o_stat  (fifo_stat)
    );

    rpi_back #(.CW(CW), .FB(FRAC_BITS), .QW(QW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (fifo_stat),
        .i_data      (pop_data),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_hit       (o_hit),
        .o_hit_param (o_hit_param),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z)
    );

endmodule
